// File: rtl/core/cabac_pkg.sv
// Shared types, constants and probability tables of the CABAC arithmetic encoder.
`timescale 1ns / 1ps

package cabac_pkg;

    // Default sizes handed to the top level
    localparam int unsigned NUM_CONTEXTS_DEF  = 16;
    localparam int unsigned PENDING_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned CTXIDX_W = 4;
    localparam int unsigned CTX_W    = 7;
    localparam int unsigned RANGE_W  = 9;
    localparam int unsigned LOW_W    = 10;
    localparam int unsigned FOLLOW_W = 16;
    localparam int unsigned STATE_W  = 6;
    localparam int unsigned RLPS_W   = 8;

    // Range and low landmarks
    localparam logic [RANGE_W-1:0] RANGE_RESET = 9'd510;
    localparam logic [RANGE_W-1:0] RANGE_MIN   = 9'd256;
    localparam logic [RANGE_W-1:0] RANGE_MAX   = 9'd510;
    localparam logic [RANGE_W-1:0] RANGE_TERM  = 9'd2;
    localparam logic [LOW_W-1:0]   LOW_HALF    = 10'd512;
    localparam logic [LOW_W-1:0]   LOW_QUART   = 10'd256;
    localparam logic [STATE_W-1:0] STATE_TOP   = 6'd62;

    // Item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_REGULAR   = 2'd0,
        OP_TERMINATE = 2'd1,
        OP_LOAD      = 2'd2,
        OP_RESTART   = 2'd3
    } t_op;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // latch a new item and read its context
        logic exec;     // apply the interval update of the latched item
        logic step;     // one renormalisation shift
        logic term_hi;  // flush: bit 9 of low with its outstanding bits
        logic term_mid; // flush: bit 8 of low
        logic term_one; // flush: closing 1
        logic close;    // release the held result as the last of the item
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_busy;  // context memory clearing pass in progress
        t_op  op;
        logic bin;
        logic exec_renorm; // range after the update needs renormalisation
        logic range_low;   // range below 256
        logic step_emits;  // the next shift emits a bit
        logic can_stage;   // a result may be staged or released this cycle
    } t_dp_status;

    // rLPS table, indexed by state and range quarter
    localparam logic [RLPS_W-1:0] LPS_RANGE [0:63][0:3] = '{
        '{8'd128,8'd176,8'd208,8'd240}, '{8'd128,8'd167,8'd197,8'd227},
        '{8'd128,8'd158,8'd187,8'd216}, '{8'd123,8'd150,8'd178,8'd205},
        '{8'd116,8'd142,8'd169,8'd195}, '{8'd111,8'd135,8'd160,8'd185},
        '{8'd105,8'd128,8'd152,8'd175}, '{8'd100,8'd122,8'd144,8'd166},
        '{8'd95,8'd116,8'd137,8'd158},  '{8'd90,8'd110,8'd130,8'd150},
        '{8'd85,8'd104,8'd123,8'd142},  '{8'd81,8'd99,8'd117,8'd135},
        '{8'd77,8'd94,8'd111,8'd128},   '{8'd73,8'd89,8'd105,8'd122},
        '{8'd69,8'd85,8'd100,8'd116},   '{8'd66,8'd80,8'd95,8'd110},
        '{8'd62,8'd76,8'd90,8'd104},    '{8'd59,8'd72,8'd86,8'd99},
        '{8'd56,8'd69,8'd81,8'd94},     '{8'd53,8'd65,8'd77,8'd89},
        '{8'd51,8'd62,8'd73,8'd85},     '{8'd48,8'd59,8'd69,8'd80},
        '{8'd46,8'd56,8'd66,8'd76},     '{8'd43,8'd53,8'd63,8'd72},
        '{8'd41,8'd50,8'd59,8'd69},     '{8'd39,8'd48,8'd56,8'd65},
        '{8'd37,8'd45,8'd54,8'd62},     '{8'd35,8'd43,8'd51,8'd59},
        '{8'd33,8'd41,8'd48,8'd56},     '{8'd32,8'd39,8'd46,8'd53},
        '{8'd30,8'd37,8'd43,8'd50},     '{8'd29,8'd35,8'd41,8'd48},
        '{8'd27,8'd33,8'd39,8'd45},     '{8'd26,8'd31,8'd37,8'd43},
        '{8'd24,8'd30,8'd35,8'd41},     '{8'd23,8'd28,8'd33,8'd39},
        '{8'd22,8'd27,8'd32,8'd37},     '{8'd21,8'd26,8'd30,8'd35},
        '{8'd20,8'd24,8'd29,8'd33},     '{8'd19,8'd23,8'd27,8'd31},
        '{8'd18,8'd22,8'd26,8'd30},     '{8'd17,8'd21,8'd25,8'd28},
        '{8'd16,8'd20,8'd23,8'd27},     '{8'd15,8'd19,8'd22,8'd25},
        '{8'd14,8'd18,8'd21,8'd24},     '{8'd14,8'd17,8'd20,8'd23},
        '{8'd13,8'd16,8'd19,8'd22},     '{8'd12,8'd15,8'd18,8'd21},
        '{8'd12,8'd14,8'd17,8'd20},     '{8'd11,8'd14,8'd16,8'd19},
        '{8'd11,8'd13,8'd15,8'd18},     '{8'd10,8'd12,8'd15,8'd17},
        '{8'd10,8'd12,8'd14,8'd16},     '{8'd9,8'd11,8'd13,8'd15},
        '{8'd9,8'd11,8'd12,8'd14},      '{8'd8,8'd10,8'd12,8'd14},
        '{8'd8,8'd9,8'd11,8'd13},       '{8'd7,8'd9,8'd11,8'd12},
        '{8'd7,8'd9,8'd10,8'd12},       '{8'd7,8'd8,8'd10,8'd11},
        '{8'd6,8'd8,8'd9,8'd11},        '{8'd6,8'd7,8'd9,8'd10},
        '{8'd6,8'd7,8'd8,8'd9},         '{8'd2,8'd2,8'd2,8'd2}
    };

    // Next state after an LPS
    localparam logic [STATE_W-1:0] AFTER_LPS [0:63] = '{
        6'd0,  6'd0,  6'd1,  6'd2,  6'd2,  6'd4,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd9,  6'd11, 6'd11, 6'd12,
        6'd13, 6'd13, 6'd15, 6'd15, 6'd16, 6'd16, 6'd18, 6'd18,
        6'd19, 6'd19, 6'd21, 6'd21, 6'd22, 6'd22, 6'd23, 6'd24,
        6'd24, 6'd25, 6'd26, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29,
        6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd32, 6'd32, 6'd33,
        6'd33, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd36,
        6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd63
    };

endpackage

// File: rtl/core/cabac_ctrl.sv
// Sequencing controller of the CABAC arithmetic encoder.
`timescale 1ns / 1ps

module cabac_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  cabac_pkg::t_dp_status i_status,
    output cabac_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RENORM,
        ST_TERM_HI,
        ST_TERM_MID,
        ST_TERM_ONE,
        ST_CLOSE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_flush;
    logic   n_flush;

    // Take items only when idle and the context memory is clear
    assign o_in_ready = (r_state == ST_IDLE) && !i_status.clear_busy;

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_flush = r_flush;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.exec_renorm ? ST_RENORM : ST_IDLE;
                if (i_status.op == cabac_pkg::OP_TERMINATE && i_status.bin) begin
                    n_flush = 1'b1;
                    n_state = ST_RENORM;
                end
                if (i_status.op == cabac_pkg::OP_LOAD ||
                    i_status.op == cabac_pkg::OP_RESTART) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RENORM: begin
                if (i_status.range_low) begin
                    // shift once; wait if an emitted bit has nowhere to go
                    if (!i_status.step_emits || i_status.can_stage) begin
                        o_cmd.step = 1'b1;
                    end
                end else if (r_flush) begin
                    n_state = ST_TERM_HI;
                end else if (i_status.can_stage) begin
                    o_cmd.close = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_TERM_HI: begin
                if (i_status.can_stage) begin
                    o_cmd.term_hi = 1'b1;
                    n_state       = ST_TERM_MID;
                end
            end
            ST_TERM_MID: begin
                if (i_status.can_stage) begin
                    o_cmd.term_mid = 1'b1;
                    n_state        = ST_TERM_ONE;
                end
            end
            ST_TERM_ONE: begin
                if (i_status.can_stage) begin
                    o_cmd.term_one = 1'b1;
                    n_state        = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (i_status.can_stage) begin
                    o_cmd.close = 1'b1;
                    n_flush     = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and flush flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
        end
    end

endmodule

// File: rtl/core/cabac_dp.sv
// Datapath of the CABAC arithmetic encoder: interval, context memory and result staging.
`timescale 1ns / 1ps

module cabac_dp #(
    parameter int unsigned NUM_CONTEXTS  = cabac_pkg::NUM_CONTEXTS_DEF,
    parameter int unsigned PENDING_WIDTH = cabac_pkg::PENDING_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cabac_pkg::t_dp_cmd                 i_cmd,
    output cabac_pkg::t_dp_status              o_status,
    input  logic [cabac_pkg::OP_W-1:0]         i_op,
    input  logic [cabac_pkg::CTXIDX_W-1:0]     i_ctx_index,
    input  logic                               i_bin_value,
    input  logic [cabac_pkg::CTX_W-1:0]        i_ctx_init,
    input  logic [cabac_pkg::RANGE_W-1:0]      i_start_range,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_out_bit,
    output logic [cabac_pkg::FOLLOW_W-1:0]     o_follow_count,
    output logic                               o_last
);

    localparam int unsigned IdxW    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int unsigned NumIdx  = 1 << cabac_pkg::CTXIDX_W;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_CONTEXTS - 1);

    // Context memory and clearing pass
    logic [cabac_pkg::CTX_W-1:0]   r_ctx_mem [NUM_CONTEXTS];
    logic [cabac_pkg::CTX_W-1:0]   r_ctx_rd;
    logic                          r_clear_busy;
    logic [IdxW-1:0]               r_clr_idx;

    // Latched item
    cabac_pkg::t_op                r_op;
    logic [IdxW-1:0]               r_idx;
    logic                          r_bin;
    logic [cabac_pkg::CTX_W-1:0]   r_init;
    logic [cabac_pkg::RANGE_W-1:0] r_start;

    // Engine state
    logic [cabac_pkg::LOW_W-1:0]   r_low;
    logic [cabac_pkg::LOW_W-1:0]   n_low;
    logic [cabac_pkg::RANGE_W-1:0] r_range;
    logic [cabac_pkg::RANGE_W-1:0] n_range;
    logic [PENDING_WIDTH-1:0]      r_pend;
    logic [PENDING_WIDTH-1:0]      n_pend;

    // Held result and output register
    logic                          r_hold_valid;
    logic                          r_hold_bit;
    logic [cabac_pkg::FOLLOW_W-1:0] r_hold_follow;
    logic                          r_out_valid;
    logic                          r_out_bit;
    logic [cabac_pkg::FOLLOW_W-1:0] r_out_follow;
    logic                          r_out_last;

    logic [IdxW-1:0]               w_wrap_tab [NumIdx];
    logic [IdxW-1:0]               w_idx;
    logic [cabac_pkg::STATE_W-1:0] w_st;
    logic                          w_mps;
    logic [cabac_pkg::RANGE_W-1:0] w_rlps;
    logic [cabac_pkg::RANGE_W-1:0] w_rmps;
    logic [cabac_pkg::RANGE_W-1:0] w_rterm;
    logic                          w_is_lps;
    logic [cabac_pkg::STATE_W-1:0] w_st_new;
    logic                          w_mps_new;
    logic [cabac_pkg::LOW_W-1:0]   w_exec_low;
    logic [cabac_pkg::RANGE_W-1:0] w_exec_range;
    logic [cabac_pkg::RANGE_W-1:0] w_clamp;
    logic [cabac_pkg::LOW_W-1:0]   w_low_sub;
    logic [cabac_pkg::FOLLOW_W-1:0] w_pend_follow;
    logic                          w_can_stage;
    logic                          w_stage_en;
    logic                          w_stage_bit;
    logic [cabac_pkg::FOLLOW_W-1:0] w_stage_follow;
    logic                          w_push;
    logic                          w_wr_en;
    logic [IdxW-1:0]               w_wr_addr;
    logic [cabac_pkg::CTX_W-1:0]   w_wr_data;

    // Wrap the context index into the memory depth
    for (genvar g = 0; g < NumIdx; g++) begin : g_wrap
        localparam int unsigned Wrap = g % NUM_CONTEXTS;
        assign w_wrap_tab[g] = IdxW'(Wrap);
    end
    assign w_idx = w_wrap_tab[i_ctx_index];

    // Latch the item and read its context
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= cabac_pkg::t_op'(i_op);
            r_idx    <= w_idx;
            r_bin    <= i_bin_value;
            r_init   <= i_ctx_init;
            r_start  <= i_start_range;
            r_ctx_rd <= r_ctx_mem[w_idx];
        end
    end

    // Interval update of a regular bin
    assign w_st     = r_ctx_rd[cabac_pkg::CTX_W-1:1];
    assign w_mps    = r_ctx_rd[0];
    assign w_rlps   = {1'b0, cabac_pkg::LPS_RANGE[w_st][r_range[7:6]]};
    assign w_rmps   = r_range - w_rlps;
    assign w_rterm  = r_range - cabac_pkg::RANGE_TERM;
    assign w_is_lps = (r_bin != w_mps);

    // Clamp the restart range into 256..510
    always_comb begin
        if (!r_start[8]) begin
            w_clamp = cabac_pkg::RANGE_MIN;
        end else if (r_start > cabac_pkg::RANGE_MAX) begin
            w_clamp = cabac_pkg::RANGE_MAX;
        end else begin
            w_clamp = r_start;
        end
    end

    // Work out the update of the latched item
    always_comb begin
        w_exec_low   = r_low;
        w_exec_range = r_range;
        w_st_new     = w_st;
        w_mps_new    = w_mps;
        unique case (r_op)
            cabac_pkg::OP_REGULAR: begin
                if (w_is_lps) begin
                    w_exec_low   = r_low + {1'b0, w_rmps};
                    w_exec_range = w_rlps;
                    w_st_new     = cabac_pkg::AFTER_LPS[w_st];
                    w_mps_new    = w_mps ^ (w_st == '0);
                end else begin
                    w_exec_range = w_rmps;
                    if (w_st < cabac_pkg::STATE_TOP) begin
                        w_st_new = w_st + 1'b1;
                    end
                end
            end
            cabac_pkg::OP_TERMINATE: begin
                if (r_bin) begin
                    w_exec_low   = r_low + {1'b0, w_rterm};
                    w_exec_range = cabac_pkg::RANGE_TERM;
                end else begin
                    w_exec_range = w_rterm;
                end
            end
            cabac_pkg::OP_LOAD: begin
                w_exec_range = r_range;
            end
            cabac_pkg::OP_RESTART: begin
                w_exec_low   = '0;
                w_exec_range = w_clamp;
            end
            default: begin
                w_exec_range = r_range;
            end
        endcase
    end

    assign w_pend_follow = cabac_pkg::FOLLOW_W'(r_pend);
    assign w_can_stage   = !r_hold_valid || !r_out_valid || i_out_ready;

    // Next engine state and the result to stage
    always_comb begin
        n_low          = r_low;
        n_range        = r_range;
        n_pend         = r_pend;
        w_low_sub      = r_low;
        w_stage_en     = 1'b0;
        w_stage_bit    = 1'b0;
        w_stage_follow = '0;
        priority if (i_cmd.exec) begin
            n_low   = w_exec_low;
            n_range = w_exec_range;
            if (r_op == cabac_pkg::OP_RESTART) begin
                n_pend = '0;
            end
        end else if (i_cmd.step) begin
            if (r_low < cabac_pkg::LOW_QUART) begin
                w_stage_en     = 1'b1;
                w_stage_follow = w_pend_follow;
                n_pend         = '0;
            end else if (r_low >= cabac_pkg::LOW_HALF) begin
                w_low_sub      = r_low - cabac_pkg::LOW_HALF;
                w_stage_en     = 1'b1;
                w_stage_bit    = 1'b1;
                w_stage_follow = w_pend_follow;
                n_pend         = '0;
            end else begin
                w_low_sub = r_low - cabac_pkg::LOW_QUART;
                if (r_pend != '1) begin
                    n_pend = r_pend + 1'b1;
                end
            end
            n_low   = {w_low_sub[cabac_pkg::LOW_W-2:0], 1'b0};
            n_range = {r_range[cabac_pkg::RANGE_W-2:0], 1'b0};
        end else if (i_cmd.term_hi) begin
            w_stage_en     = 1'b1;
            w_stage_bit    = r_low[9];
            w_stage_follow = w_pend_follow;
            n_pend         = '0;
        end else if (i_cmd.term_mid) begin
            w_stage_en  = 1'b1;
            w_stage_bit = r_low[8];
        end else if (i_cmd.term_one) begin
            w_stage_en  = 1'b1;
            w_stage_bit = 1'b1;
        end else begin
            n_low = r_low;
        end
    end

    // Advance the engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '0;
            r_range <= cabac_pkg::RANGE_RESET;
            r_pend  <= '0;
        end else begin
            r_low   <= n_low;
            r_range <= n_range;
            r_pend  <= n_pend;
        end
    end

    // Select the context memory write
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = {w_st_new, w_mps_new};
        priority if (r_clear_busy) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_idx;
            w_wr_data = '0;
        end else if (i_cmd.exec && r_op == cabac_pkg::OP_REGULAR) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.exec && r_op == cabac_pkg::OP_LOAD) begin
            w_wr_en   = 1'b1;
            w_wr_data = r_init;
        end else begin
            w_wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ctx_mem[w_wr_addr] <= w_wr_data;
        end
    end

    // Sweep the context memory to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_busy <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clear_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LastIdx) begin
                r_clear_busy <= 1'b0;
            end
        end
    end

    // Hold one result back so the last of an item can be marked
    assign w_push = r_hold_valid && (w_stage_en || i_cmd.close);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (w_stage_en) begin
            r_hold_valid <= 1'b1;
        end else if (i_cmd.close) begin
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stage_en) begin
            r_hold_bit    <= w_stage_bit;
            r_hold_follow <= w_stage_follow;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_bit    <= r_hold_bit;
            r_out_follow <= r_hold_follow;
            r_out_last   <= i_cmd.close;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_bit      = r_out_bit;
    assign o_follow_count = r_out_follow;
    assign o_last         = r_out_last;

    // Status towards the controller
    always_comb begin
        o_status             = '0;
        o_status.clear_busy  = r_clear_busy;
        o_status.op          = r_op;
        o_status.bin         = r_bin;
        o_status.exec_renorm = !w_exec_range[8];
        o_status.range_low   = !r_range[8];
        o_status.step_emits  = r_low[9] || !r_low[8];
        o_status.can_stage   = w_can_stage;
    end

    // A pushed result never overwrites one still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!r_out_valid || i_out_ready))
        else $error("result pushed over a waiting output");

    // The range never collapses to zero
    a_range_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_range != '0)
        else $error("range reached zero");

    // A new item finds no result held back from the previous one
    a_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> !r_hold_valid)
        else $error("item accepted with a result still held");

    // Renormalisation shifts only while the range is below 256
    a_step_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !r_range[8])
        else $error("renormalisation step with full range");

    // The flush clears the outstanding count before its raw bits
    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.term_hi |=> (r_pend == '0))
        else $error("outstanding bits left after flush");

endmodule

// File: rtl/core/cabac_binary_arithmetic_encoder.sv
// Top level of the CABAC binary arithmetic encoder.
`timescale 1ns / 1ps

// Encodes one operation per item: a regular bin against a context, a terminate
// bin (a terminating 1 flushes the engine), a context load or an engine restart.
// Each emitted bit leaves as one result item carrying the count of inverted
// outstanding bits that follow it, and the final result of an item is marked
// by o_last. Items are handled one at a time: a load, a restart, or a bin that
// needs no renormalisation is latched, then updated; a bin that renormalises
// also takes the single shared renormalisation step, which moves one bit position
// per cycle while a bit it emits can be staged; a terminating 1 then flushes bit 9,
// bit 8 and a closing 1. A full output register stalls a step that has a bit
// to emit. After reset a clearing pass zeroes the context memory before the
// first item is taken. Context indexes wrap modulo NUM_CONTEXTS.
module cabac_binary_arithmetic_encoder #(
    parameter int unsigned NUM_CONTEXTS  = cabac_pkg::NUM_CONTEXTS_DEF,
    parameter int unsigned PENDING_WIDTH = cabac_pkg::PENDING_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [cabac_pkg::OP_W-1:0]     i_op,
    input  logic [cabac_pkg::CTXIDX_W-1:0] i_ctx_index,
    input  logic                           i_bin_value,
    input  logic [cabac_pkg::CTX_W-1:0]    i_ctx_init,
    input  logic [cabac_pkg::RANGE_W-1:0]  i_start_range,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_out_bit,
    output logic [cabac_pkg::FOLLOW_W-1:0] o_follow_count,
    output logic                           o_last
);

    cabac_pkg::t_dp_cmd    w_cmd;
    cabac_pkg::t_dp_status w_status;

    // Sequence the item
    cabac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic engine, context memory and result staging
    cabac_dp #(
        .NUM_CONTEXTS  (NUM_CONTEXTS),
        .PENDING_WIDTH (PENDING_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_op           (i_op),
        .i_ctx_index    (i_ctx_index),
        .i_bin_value    (i_bin_value),
        .i_ctx_init     (i_ctx_init),
        .i_start_range  (i_start_range),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_bit      (o_out_bit),
        .o_follow_count (o_follow_count),
        .o_last         (o_last)
    );

endmodule

// File: bench/tb_cabac_binary_arithmetic_encoder.sv
// Self-checking bench for the CABAC binary arithmetic encoder: directed cases, then random streams.
`timescale 1ns / 1ps

module tb_cabac_binary_arithmetic_encoder;

    localparam int NUM_CTX           = cabac_pkg::NUM_CONTEXTS_DEF;
    localparam int PEND_MAX          = (1 << cabac_pkg::PENDING_WIDTH_DEF) - 1;
    localparam int IDX_W             = cabac_pkg::CTXIDX_W;
    localparam int INIT_W            = cabac_pkg::CTX_W;
    localparam int START_W           = cabac_pkg::RANGE_W;
    localparam int MAX_BITS_ITEM     = 10;
    localparam int RENORM_SHIFTS     = 7;
    localparam int WAIT_MAX          = 18;
    localparam int RANDOM_ITEMS      = 90;
    localparam int OUTSTANDING_ITEMS = 12;
    localparam int DRAIN_CYCLES      = 40;
    localparam int CYCLE_LIMIT       = 600000;
    localparam int REPORT_LINES      = 100;

    // rLPS by probability state and range quarter
    localparam logic [7:0] QUARTER_LPS [0:63][0:3] = '{
        '{128,176,208,240}, '{128,167,197,227}, '{128,158,187,216}, '{123,150,178,205},
        '{116,142,169,195}, '{111,135,160,185}, '{105,128,152,175}, '{100,122,144,166},
        '{95,116,137,158},  '{90,110,130,150},  '{85,104,123,142},  '{81,99,117,135},
        '{77,94,111,128},   '{73,89,105,122},   '{69,85,100,116},   '{66,80,95,110},
        '{62,76,90,104},    '{59,72,86,99},     '{56,69,81,94},     '{53,65,77,89},
        '{51,62,73,85},     '{48,59,69,80},     '{46,56,66,76},     '{43,53,63,72},
        '{41,50,59,69},     '{39,48,56,65},     '{37,45,54,62},     '{35,43,51,59},
        '{33,41,48,56},     '{32,39,46,53},     '{30,37,43,50},     '{29,35,41,48},
        '{27,33,39,45},     '{26,31,37,43},     '{24,30,35,41},     '{23,28,33,39},
        '{22,27,32,37},     '{21,26,30,35},     '{20,24,29,33},     '{19,23,27,31},
        '{18,22,26,30},     '{17,21,25,28},     '{16,20,23,27},     '{15,19,22,25},
        '{14,18,21,24},     '{14,17,20,23},     '{13,16,19,22},     '{12,15,18,21},
        '{12,14,17,20},     '{11,14,16,19},     '{11,13,15,18},     '{10,12,15,17},
        '{10,12,14,16},     '{9,11,13,15},      '{9,11,12,14},      '{8,10,12,14},
        '{8,9,11,13},       '{7,9,11,12},       '{7,9,10,12},       '{7,8,10,11},
        '{6,8,9,11},        '{6,7,9,10},        '{6,7,8,9},         '{2,2,2,2}
    };

    // Probability state reached after an LPS
    localparam logic [5:0] LPS_NEXT [0:63] = '{
        0,  0,  1,  2,  2,  4,  4,  5,  6,  7,  8,  9,  9,  11, 11, 12,
        13, 13, 15, 15, 16, 16, 18, 18, 19, 19, 21, 21, 22, 22, 23, 24,
        24, 25, 26, 26, 27, 27, 28, 29, 29, 30, 30, 30, 31, 32, 32, 33,
        33, 33, 34, 34, 35, 35, 35, 36, 36, 36, 37, 37, 37, 38, 38, 63
    };

    typedef struct packed {
        logic                           out_bit;
        logic [cabac_pkg::FOLLOW_W-1:0] follow;
        logic                           last;
    } t_coded_bit;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [cabac_pkg::OP_W-1:0]      i_op;
    logic [cabac_pkg::CTXIDX_W-1:0]  i_ctx_index;
    logic                            i_bin_value;
    logic [cabac_pkg::CTX_W-1:0]     i_ctx_init;
    logic [cabac_pkg::RANGE_W-1:0]   i_start_range;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic                            o_out_bit;
    logic [cabac_pkg::FOLLOW_W-1:0]  o_follow_count;
    logic                            o_last;

    // Engine state as the encoder should hold it
    logic [cabac_pkg::LOW_W-1:0]     enc_low;
    logic [cabac_pkg::RANGE_W-1:0]   enc_range;
    int unsigned                     enc_pending;
    logic [cabac_pkg::CTX_W-1:0]     ctx_mem [0:NUM_CTX-1];

    t_coded_bit                      item_bits [0:MAX_BITS_ITEM-1];
    int                              item_bit_count;
    t_coded_bit                      expected_bits [$];

    bit                              quiet_flow = 1'b0;
    int                              ready_hold = 0;
    int                              fail_count = 0;
    int                              cycle_count = 0;

    cabac_binary_arithmetic_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_ctx_index    (i_ctx_index),
        .i_bin_value    (i_bin_value),
        .i_ctx_init     (i_ctx_init),
        .i_start_range  (i_start_range),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_bit      (o_out_bit),
        .o_follow_count (o_follow_count),
        .o_last         (o_last)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Idle cycles before an item: often none, sometimes short, sometimes up to the maximum
    function automatic int draw_wait();
        if (quiet_flow)
            return 0;
        case ($urandom_range(0, 3))
            0, 1: return 0;
            2: return $urandom_range(1, 3);
            default: return $urandom_range(0, WAIT_MAX);
        endcase
    endfunction

    function automatic void add_bit(input logic b, input int unsigned follow);
        if (item_bit_count < MAX_BITS_ITEM) begin
            item_bits[item_bit_count] = {b, follow[cabac_pkg::FOLLOW_W-1:0], 1'b0};
            item_bit_count++;
        end
    endfunction

    // Emit a bit carrying the outstanding bits behind it
    function automatic void put_bit(input logic b);
        add_bit(b, enc_pending);
        enc_pending = 0;
    endfunction

    function automatic void renormalise();
        for (int k = 0; k < RENORM_SHIFTS && enc_range < 256; k++) begin
            if (enc_low < 256) begin
                put_bit(1'b0);
            end else if (enc_low >= 512) begin
                enc_low = enc_low - 10'd512;
                put_bit(1'b1);
            end else begin
                // straddling the midpoint: defer the bit, saturating the count
                enc_low = enc_low - 10'd256;
                if (enc_pending < PEND_MAX)
                    enc_pending++;
            end
            enc_range = enc_range << 1;
            enc_low   = enc_low << 1;
        end
    endfunction

    // Advance the engine by one item and queue the bits it should emit
    function automatic void encode_item(input cabac_pkg::t_op op,
                                        input logic [cabac_pkg::CTXIDX_W-1:0] idx,
                                        input logic bin_val,
                                        input logic [cabac_pkg::CTX_W-1:0] init,
                                        input logic [cabac_pkg::RANGE_W-1:0] start);
        logic [5:0] st;
        logic       mps;
        logic [7:0] rlps;
        int         slot;
        item_bit_count = 0;
        slot = idx % NUM_CTX;
        case (op)
            cabac_pkg::OP_REGULAR: begin
                st   = ctx_mem[slot][cabac_pkg::CTX_W-1:1];
                mps  = ctx_mem[slot][0];
                rlps = QUARTER_LPS[st][enc_range[7:6]];
                enc_range = enc_range - rlps;
                if (bin_val != mps) begin
                    enc_low   = enc_low + enc_range;
                    enc_range = rlps;
                    if (st == 0)
                        mps = ~mps;
                    st = LPS_NEXT[st];
                end else if (st < 62) begin
                    st++;
                end
                ctx_mem[slot] = {st, mps};
                renormalise();
            end
            cabac_pkg::OP_TERMINATE: begin
                enc_range = enc_range - 9'd2;
                if (bin_val) begin
                    // flush: renormalise, then bit 9, bit 8 and a closing 1
                    enc_low   = enc_low + enc_range;
                    enc_range = 9'd2;
                    renormalise();
                    put_bit(enc_low[9]);
                    add_bit(enc_low[8], 0);
                    add_bit(1'b1, 0);
                end else begin
                    renormalise();
                end
            end
            cabac_pkg::OP_LOAD: begin
                ctx_mem[slot] = init;
            end
            default: begin
                if (start < 256)
                    enc_range = 9'd256;
                else if (start > 510)
                    enc_range = 9'd510;
                else
                    enc_range = start;
                enc_low     = '0;
                enc_pending = 0;
            end
        endcase
        for (int n = 0; n < item_bit_count; n++) begin
            if (n == item_bit_count - 1)
                item_bits[n].last = 1'b1;
            expected_bits.push_back(item_bits[n]);
        end
    endfunction

    // Offer one item after a random gap, hold it until taken, then predict its bits
    task automatic issue_item(input cabac_pkg::t_op op,
                              input logic [cabac_pkg::CTXIDX_W-1:0] idx,
                              input logic bin_val,
                              input logic [cabac_pkg::CTX_W-1:0] init,
                              input logic [cabac_pkg::RANGE_W-1:0] start);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_ctx_index   <= idx;
        i_bin_value   <= bin_val;
        i_ctx_init    <= init;
        i_start_range <= start;
        do
            @(posedge i_clk);
        while (o_in_ready !== 1'b1);
        encode_item(op, idx, bin_val, init, start);
    endtask

    // Draw every field of an item over its full range
    task automatic draw_fields(output logic [cabac_pkg::CTXIDX_W-1:0] idx,
                               output logic bin_val,
                               output logic [cabac_pkg::CTX_W-1:0] init,
                               output logic [cabac_pkg::RANGE_W-1:0] start);
        idx     = IDX_W'($urandom_range(0, 15));
        bin_val = 1'($urandom_range(0, 1));
        init    = INIT_W'($urandom_range(0, 127));
        start   = START_W'($urandom_range(0, 511));
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned wanted);
        if (fail_count < REPORT_LINES)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
        fail_count++;
    endtask

    // Check each result against the oldest prediction, then stall the output at random
    always @(posedge i_clk) begin : result_check
        t_coded_bit want;
        int         stall;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_bits.size() == 0) begin
                report_mismatch("result with no bit outstanding", 32'(o_out_bit), 0);
            end else begin
                want = expected_bits.pop_front();
                if (o_out_bit !== want.out_bit)
                    report_mismatch("out_bit", 32'(o_out_bit), 32'(want.out_bit));
                if (o_follow_count !== want.follow)
                    report_mismatch("follow_count", 32'(o_follow_count), 32'(want.follow));
                if (o_last !== want.last)
                    report_mismatch("last", 32'(o_last), 32'(want.last));
            end
            stall = draw_wait();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                ready_hold = stall;
            end
        end else if (ready_hold > 0) begin
            if (ready_hold == 1)
                i_out_ready <= 1'b1;
            ready_hold--;
        end
    end

    // Contexts straight out of the clearing pass: state 0, MPS 0
    task automatic test_reset_contexts();
        issue_item(cabac_pkg::OP_REGULAR, 4'd0, 1'b0, 7'd0, 9'd0);
        issue_item(cabac_pkg::OP_REGULAR, 4'd15, 1'b1, 7'd0, 9'd0); // LPS at state 0 flips MPS
        issue_item(cabac_pkg::OP_REGULAR, 4'd15, 1'b1, 7'd0, 9'd0);
    endtask

    // Loaded contexts at the top states
    task automatic test_context_loads();
        issue_item(cabac_pkg::OP_LOAD, 4'd3, 1'b0, 7'd127, 9'd0);
        issue_item(cabac_pkg::OP_REGULAR, 4'd3, 1'b1, 7'd0, 9'd0);  // MPS at state 63 holds it
        issue_item(cabac_pkg::OP_REGULAR, 4'd3, 1'b0, 7'd0, 9'd0);  // LPS at 63: rLPS 2, 7 shifts
        issue_item(cabac_pkg::OP_LOAD, 4'd9, 1'b1, 7'd124, 9'd0);
        issue_item(cabac_pkg::OP_REGULAR, 4'd9, 1'b0, 7'd0, 9'd0);  // state 62 does not advance
        issue_item(cabac_pkg::OP_REGULAR, 4'd9, 1'b1, 7'd0, 9'd0);
    endtask

    // Terminate bins, including a flush that is not followed by a restart
    task automatic test_terminate_flush();
        issue_item(cabac_pkg::OP_TERMINATE, 4'd0, 1'b0, 7'd0, 9'd0);
        issue_item(cabac_pkg::OP_TERMINATE, 4'd0, 1'b1, 7'd0, 9'd0);
        issue_item(cabac_pkg::OP_REGULAR, 4'd0, 1'b0, 7'd0, 9'd0);
        issue_item(cabac_pkg::OP_TERMINATE, 4'd0, 1'b1, 7'd0, 9'd0);
        issue_item(cabac_pkg::OP_RESTART, 4'd0, 1'b0, 7'd0, 9'd510);
    endtask

    // Restart ranges below, above and inside the legal band
    task automatic test_restart_clamp();
        issue_item(cabac_pkg::OP_RESTART, 4'd0, 1'b0, 7'd0, 9'd0);
        issue_item(cabac_pkg::OP_REGULAR, 4'd15, 1'b0, 7'd0, 9'd0);
        issue_item(cabac_pkg::OP_RESTART, 4'd0, 1'b0, 7'd0, 9'd511);
        issue_item(cabac_pkg::OP_REGULAR, 4'd15, 1'b1, 7'd0, 9'd0);
        issue_item(cabac_pkg::OP_RESTART, 4'd0, 1'b0, 7'd0, 9'd300);
        issue_item(cabac_pkg::OP_TERMINATE, 4'd0, 1'b0, 7'd0, 9'd0);
    endtask

    // Build a long run of outstanding bits, then flush it out.
    // With low 256 and range 256, an LPS at state 63 lands low on 510 and its
    // seven shifts all straddle the midpoint, bringing low back to 256.
    task automatic test_outstanding_run();
        quiet_flow = 1'b1;
        issue_item(cabac_pkg::OP_RESTART, 4'd0, 1'b0, 7'd0, 9'd256);
        issue_item(cabac_pkg::OP_LOAD, 4'd5, 1'b0, 7'd126, 9'd0);
        repeat (OUTSTANDING_ITEMS)
            issue_item(cabac_pkg::OP_REGULAR, 4'd5, 1'b1, 7'd0, 9'd0);
        issue_item(cabac_pkg::OP_TERMINATE, 4'd0, 1'b1, 7'd0, 9'd0);
        issue_item(cabac_pkg::OP_RESTART, 4'd0, 1'b0, 7'd0, 9'd510);
        quiet_flow = 1'b0;
    endtask

    // Streams of restart, loads, bins mostly on the MPS, closed by a flush; some left broken
    task automatic test_random_streams();
        int                             sent;
        logic [cabac_pkg::CTXIDX_W-1:0] idx;
        logic                           bin_val;
        logic [cabac_pkg::CTX_W-1:0]    init;
        logic [cabac_pkg::RANGE_W-1:0]  start;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet_flow = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) != 0) begin
                draw_fields(idx, bin_val, init, start);
                issue_item(cabac_pkg::OP_RESTART, idx, bin_val, init, start);
                sent++;
            end
            repeat ($urandom_range(0, 3)) begin
                draw_fields(idx, bin_val, init, start);
                issue_item(cabac_pkg::OP_LOAD, idx, bin_val, init, start);
                sent++;
            end
            repeat ($urandom_range(4, 16)) begin
                draw_fields(idx, bin_val, init, start);
                if ($urandom_range(0, 9) == 0) begin
                    issue_item(cabac_pkg::OP_TERMINATE, idx, 1'b0, init, start);
                end else begin
                    bin_val = ctx_mem[idx % NUM_CTX][0];
                    if ($urandom_range(0, 3) == 0)
                        bin_val = ~bin_val;
                    issue_item(cabac_pkg::OP_REGULAR, idx, bin_val, init, start);
                end
                sent++;
            end
            if ($urandom_range(0, 5) != 0) begin
                draw_fields(idx, bin_val, init, start);
                issue_item(cabac_pkg::OP_TERMINATE, idx, 1'b1, init, start);
                sent++;
            end
        end
        quiet_flow = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_op          <= cabac_pkg::OP_REGULAR;
        i_ctx_index   <= '0;
        i_bin_value   <= 1'b0;
        i_ctx_init    <= '0;
        i_start_range <= '0;
        i_out_ready   <= 1'b1;
        enc_low     = '0;
        enc_range   = 9'd510;
        enc_pending = 0;
        for (int c = 0; c < NUM_CTX; c++)
            ctx_mem[c] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contexts();
        test_context_loads();
        test_terminate_flush();
        test_restart_clamp();
        test_outstanding_run();
        test_random_streams();
        i_in_valid <= 1'b0;

        // Drain the outstanding bits, then watch for strays
        while (expected_bits.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: cabac_binary_arithmetic_encoder.f
rtl/core/cabac_pkg.sv
rtl/core/cabac_ctrl.sv
rtl/core/cabac_dp.sv
rtl/core/cabac_binary_arithmetic_encoder.sv
bench/tb_cabac_binary_arithmetic_encoder.sv
